// ===== rtl/core/rrp_pkg.sv =====
// Shared types and constants for the RESP request parser.
`timescale 1ns / 1ps
package rrp_pkg;

	typedef enum logic [3:0] {
		PH_STAR,
		PH_CNT,
		PH_CNT_LF,
		PH_DOLLAR,
		PH_LEN,
		PH_LEN_LF,
		PH_DATA,
		PH_CR,
		PH_LF,
		PH_ERR
	} phase_t;

	typedef enum logic [1:0] {
		EV_DATA = 2'd0,
		EV_ARG  = 2'd1,
		EV_ERR  = 2'd2
	} event_t;

	typedef enum logic [2:0] {
		ERR_ARRAY_MARK   = 3'd0,
		ERR_COUNT        = 3'd1,
		ERR_RANGE        = 3'd2,
		ERR_BULK_MARK    = 3'd3,
		ERR_LENGTH       = 3'd4,
		ERR_PAYLOAD_CRLF = 3'd5,
		ERR_OVERFLOW     = 3'd6
	} err_t;

	typedef struct packed {
		logic        valid;
		event_t      ev;
		logic [7:0]  data;
		logic [5:0]  idx;
		logic [31:0] len;
		logic        last;
		err_t        code;
	} result_t;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam int         ARG_W         = 7;
	localparam logic [6:0] MAX_ARGS_RST  = 7'd64;
	localparam logic       REG_MAX_ARGS  = 1'b0;

endpackage

// ===== rtl/core/rrp_parse.sv =====
// Parser state machine: consumes one byte per step and forms the result word.
`timescale 1ns / 1ps
module rrp_parse
	import rrp_pkg::*;
#(
	parameter int LEN_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic [ARG_W-1:0] limit,
	output result_t          res
);

	localparam int WW = LEN_BITS + 4;
	localparam int PW = (LEN_BITS > 32) ? LEN_BITS : 32;

	phase_t              phase_q, phase_d;
	logic [LEN_BITS-1:0] accum_q, accum_d;
	logic                neg_q, neg_d;
	logic                digit_q, digit_d;
	logic                sign_q, sign_d;
	logic [ARG_W-1:0]    total_q, total_d;
	logic [ARG_W-1:0]    pos_q, pos_d;
	logic [LEN_BITS-1:0] blen_q, blen_d;
	logic [LEN_BITS-1:0] left_q, left_d;

	logic                fail;
	err_t                fcode;
	err_t                bad_num;
	logic                is_digit;
	logic                is_sign;
	logic [3:0]          dval;
	logic [WW-1:0]       acc_x10;
	logic                ovf;
	logic                last;
	logic [PW-1:0]       blen_ext;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_sign  = ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) && !sign_q && !digit_q;
	assign dval     = is_digit ? rx_byte[3:0] : 4'd0;
	assign acc_x10  = (WW'(accum_q) << 3) + (WW'(accum_q) << 1) + WW'(dval);
	assign ovf      = |acc_x10[WW-1:LEN_BITS];
	assign bad_num  = (phase_q == PH_CNT) ? ERR_COUNT : ERR_LENGTH;
	assign last     = ({1'b0, pos_q} + 8'd1) >= {1'b0, total_q};
	assign blen_ext = PW'(blen_q);

	// next state
	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		neg_d   = neg_q;
		digit_d = digit_q;
		sign_d  = sign_q;
		total_d = total_q;
		pos_d   = pos_q;
		blen_d  = blen_q;
		left_d  = left_q;
		fail    = 1'b0;
		fcode   = ERR_ARRAY_MARK;
		case (phase_q)
			PH_STAR: begin
				if (rx_byte != CH_STAR) begin
					fail  = 1'b1;
					fcode = ERR_ARRAY_MARK;
				end else begin
					accum_d = '0;
					neg_d   = 1'b0;
					digit_d = 1'b0;
					sign_d  = 1'b0;
					phase_d = PH_CNT;
				end
			end
			PH_CNT, PH_LEN: begin
				if (rx_byte == CH_CR) begin
					if (!digit_q) begin
						fail  = 1'b1;
						fcode = bad_num;
					end else begin
						phase_d = (phase_q == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
					end
				end else if (is_sign) begin
					sign_d = 1'b1;
					neg_d  = (rx_byte == CH_MINUS);
				end else if (!is_digit) begin
					fail  = 1'b1;
					fcode = bad_num;
				end else if (ovf) begin
					fail  = 1'b1;
					fcode = ERR_OVERFLOW;
				end else begin
					accum_d = acc_x10[LEN_BITS-1:0];
					digit_d = 1'b1;
				end
			end
			PH_CNT_LF: begin
				if (rx_byte != CH_LF) begin
					fail  = 1'b1;
					fcode = ERR_COUNT;
				end else if ((accum_q == '0) || neg_q
					|| (accum_q > LEN_BITS'(limit))) begin
					fail  = 1'b1;
					fcode = ERR_RANGE;
				end else begin
					total_d = accum_q[ARG_W-1:0];
					pos_d   = '0;
					phase_d = PH_DOLLAR;
				end
			end
			PH_DOLLAR: begin
				if (rx_byte != CH_DOLLAR) begin
					fail  = 1'b1;
					fcode = ERR_BULK_MARK;
				end else begin
					accum_d = '0;
					neg_d   = 1'b0;
					digit_d = 1'b0;
					sign_d  = 1'b0;
					phase_d = PH_LEN;
				end
			end
			PH_LEN_LF: begin
				if ((rx_byte != CH_LF) || (neg_q && (accum_q != '0))) begin
					fail  = 1'b1;
					fcode = ERR_LENGTH;
				end else begin
					blen_d  = accum_q;
					left_d  = accum_q;
					phase_d = (accum_q != '0) ? PH_DATA : PH_CR;
				end
			end
			PH_DATA: begin
				left_d = left_q - LEN_BITS'(1);
				if (left_q == LEN_BITS'(1)) begin
					phase_d = PH_CR;
				end
			end
			PH_CR: begin
				if (rx_byte != CH_CR) begin
					fail  = 1'b1;
					fcode = ERR_PAYLOAD_CRLF;
				end else begin
					phase_d = PH_LF;
				end
			end
			PH_LF: begin
				if (rx_byte != CH_LF) begin
					fail  = 1'b1;
					fcode = ERR_PAYLOAD_CRLF;
				end else if (last) begin
					pos_d   = '0;
					total_d = '0;
					phase_d = PH_STAR;
				end else begin
					pos_d   = pos_q + 7'd1;
					phase_d = PH_DOLLAR;
				end
			end
			PH_ERR: begin
				phase_d = PH_ERR;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
		if (fail) begin
			phase_d = PH_ERR;
		end
	end

	// result word
	always_comb begin
		res       = '0;
		res.idx   = pos_q[5:0];
		res.ev    = EV_DATA;
		res.code  = ERR_ARRAY_MARK;
		if (step) begin
			if (fail) begin
				res.valid = 1'b1;
				res.ev    = EV_ERR;
				res.code  = fcode;
			end else if (phase_q == PH_DATA) begin
				res.valid = 1'b1;
				res.ev    = EV_DATA;
				res.data  = rx_byte;
			end else if ((phase_q == PH_LF) && (rx_byte == CH_LF)) begin
				res.valid = 1'b1;
				res.ev    = EV_ARG;
				res.len   = blen_ext[31:0];
				res.last  = last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STAR;
			accum_q <= '0;
			neg_q   <= 1'b0;
			digit_q <= 1'b0;
			sign_q  <= 1'b0;
			total_q <= '0;
			pos_q   <= '0;
			blen_q  <= '0;
			left_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			neg_q   <= neg_d;
			digit_q <= digit_d;
			sign_q  <= sign_d;
			total_q <= total_d;
			pos_q   <= pos_d;
			blen_q  <= blen_d;
			left_q  <= left_d;
		end
	end

`ifndef SYNTH
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR) |-> !res.valid)
		else $error("result produced after latched error");

	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (left_q != '0))
		else $error("payload phase with no bytes left");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_DOLLAR) || (phase_q == PH_LEN) || (phase_q == PH_LEN_LF)
		|| (phase_q == PH_DATA) || (phase_q == PH_CR) || (phase_q == PH_LF))
		|-> (pos_q < total_q))
		else $error("argument index beyond count");

	a_fail_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(step && fail) |=> (phase_q == PH_ERR))
		else $error("error not latched");
`endif

endmodule

// ===== rtl/core/resp_request_parser_core.sv =====
// Top level: RESP request parser with stream ports and register port.
`timescale 1ns / 1ps
// Each accepted byte is held in the input stage, parsed, and its word is registered in the output register.
// Throughput: one byte per cycle while the output register is empty or being
// taken; the input stage and the output register then advance together.
// Reset: parser expects the array marker, no word pending, max_args = 64.
// A parse error is reported once and then latched until reset.
module resp_request_parser_core
	import rrp_pkg::*;
#(
	parameter int MAX_ARGS = 64,
	parameter int LEN_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [7:0] data_byte, [13:8] arg_index,
	                               // [45:14] arg_length, [48:46] error_code
	output logic [1:0]  m_tuser,   // [1:0] event_res
	output logic        m_tlast,   // last_of_command
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [ARG_W-1:0] LIM_CAP = ARG_W'((MAX_ARGS > 127) ? 127 : MAX_ARGS);

	logic [ARG_W-1:0] max_args_q;
	logic [ARG_W-1:0] limit;
	logic [7:0]       byte_s1;
	logic             vld_s1;
	result_t          res;
	result_t          res_s2;
	logic             out_vld_s2;
	logic             out_free;
	logic             advance;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_ARGS) ? {25'd0, max_args_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= MAX_ARGS_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_ARGS)) begin
			max_args_q <= pwdata[ARG_W-1:0];
		end
	end

	assign limit = (max_args_q < LIM_CAP) ? max_args_q : LIM_CAP;

	// input stage
	assign out_free = !out_vld_s2 || m_tready;
	assign advance  = vld_s1 && out_free;
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	rrp_parse #(
		.LEN_BITS (LEN_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.limit   (limit),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s2 <= 1'b0;
		end else if (out_free) begin
			out_vld_s2 <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = out_vld_s2;
	assign m_tuser  = res_s2.ev;
	assign m_tlast  = res_s2.last;
	assign m_tdata  = {7'd0, res_s2.code, res_s2.len, res_s2.idx, res_s2.data};

endmodule
